FILE: rtl/c6se_pkg.sv
// Shared types, opcodes and helpers for the 6502 subset execute block.
`default_nettype none

package c6se_pkg;

  // Stream widths
  localparam int IN_W  = 32;
  localparam int OUT_W = 80;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_BRK_VECTOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR = 1'b1;

  localparam logic [15:0] RESET_START = 16'hC000;

  // Status bits: N V - B D I Z C
  localparam logic [7:0] FLAG_N = 8'h80;
  localparam logic [7:0] FLAG_V = 8'h40;
  localparam logic [7:0] FLAG_B = 8'h10;
  localparam logic [7:0] FLAG_D = 8'h08;
  localparam logic [7:0] FLAG_I = 8'h04;
  localparam logic [7:0] FLAG_Z = 8'h02;
  localparam logic [7:0] FLAG_C = 8'h01;

  // Opcodes of the subset
  localparam logic [7:0] OP_BRK     = 8'h00;
  localparam logic [7:0] OP_PHP     = 8'h08;
  localparam logic [7:0] OP_ORA_IMM = 8'h09;
  localparam logic [7:0] OP_BPL     = 8'h10;
  localparam logic [7:0] OP_CLC     = 8'h18;
  localparam logic [7:0] OP_JSR     = 8'h20;
  localparam logic [7:0] OP_BIT_ZP  = 8'h24;
  localparam logic [7:0] OP_PLP     = 8'h28;
  localparam logic [7:0] OP_AND_IMM = 8'h29;
  localparam logic [7:0] OP_BMI     = 8'h30;
  localparam logic [7:0] OP_SEC     = 8'h38;
  localparam logic [7:0] OP_RTI     = 8'h40;
  localparam logic [7:0] OP_PHA     = 8'h48;
  localparam logic [7:0] OP_EOR_IMM = 8'h49;
  localparam logic [7:0] OP_JMP_ABS = 8'h4C;
  localparam logic [7:0] OP_BVC     = 8'h50;
  localparam logic [7:0] OP_RTS     = 8'h60;
  localparam logic [7:0] OP_PLA     = 8'h68;
  localparam logic [7:0] OP_BVS     = 8'h70;
  localparam logic [7:0] OP_SEI     = 8'h78;
  localparam logic [7:0] OP_STA_ZP  = 8'h85;
  localparam logic [7:0] OP_STX_ZP  = 8'h86;
  localparam logic [7:0] OP_STA_ABS = 8'h8D;
  localparam logic [7:0] OP_BCC     = 8'h90;
  localparam logic [7:0] OP_TXS     = 8'h9A;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ABS = 8'hAD;
  localparam logic [7:0] OP_BCS     = 8'hB0;
  localparam logic [7:0] OP_CLV     = 8'hB8;
  localparam logic [7:0] OP_CMP_IMM = 8'hC9;
  localparam logic [7:0] OP_BNE     = 8'hD0;
  localparam logic [7:0] OP_CLD     = 8'hD8;
  localparam logic [7:0] OP_NOP     = 8'hEA;
  localparam logic [7:0] OP_BEQ     = 8'hF0;
  localparam logic [7:0] OP_SED     = 8'hF8;

  // How an accepted instruction continues after its first cycle
  typedef enum logic [1:0] {
    K_DONE,
    K_PUSH,
    K_PULL
  } c6se_kind_t;

  // Decoder output for the accept cycle
  typedef struct packed {
    c6se_kind_t  kind;
    logic [15:0] npc;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  p;
    logic [7:0]  sp;
    logic        wr;
    logic [15:0] waddr;
    logic [7:0]  wdata;
    logic [2:0]  cyc;
    logic        illegal;
    logic        st_we;
    logic [7:0]  st_data;
    logic        st_rd;
    logic [1:0]  push_left;
    logic [7:0]  push_b0;
    logic [7:0]  push_b1;
    logic [1:0]  pull_last;
  } c6se_exec_t;

  // One result transaction
  typedef struct packed {
    logic [15:0] npc;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  p;
    logic [7:0]  sp;
    logic        wr;
    logic [15:0] waddr;
    logic [7:0]  wdata;
    logic [2:0]  cyc;
    logic        illegal;
  } c6se_result_t;

  // Update N and Z of a status byte from a result byte
  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] r;
    r = p & ~(FLAG_N | FLAG_Z);
    if (v[7]) r = r | FLAG_N;
    if (v == 8'h00) r = r | FLAG_Z;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/c6se_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module c6se_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/c6se_decode.sv
// Instruction decode and combinational execute for the accept cycle.
`default_nettype none

module c6se_decode
  import c6se_pkg::*;
(
  input  wire logic [7:0]  cmd,
  input  wire logic [15:0] operand,
  input  wire logic [7:0]  mem_data,
  input  wire logic [15:0] pc,
  input  wire logic [7:0]  a,
  input  wire logic [7:0]  x,
  input  wire logic [7:0]  p,
  input  wire logic [7:0]  sp,
  output c6se_exec_t       ex
);

  logic [7:0]  lo;
  logic [15:0] pc1, pc2, pc3;
  logic [15:0] boff, btgt;
  logic [7:0]  cmp_diff;
  logic        br_en, br_take;

  assign lo       = operand[7:0];
  assign pc1      = pc + 16'd1;
  assign pc2      = pc + 16'd2;
  assign pc3      = pc + 16'd3;
  assign boff     = {{8{lo[7]}}, lo};
  assign btgt     = pc2 + boff;
  assign cmp_diff = a - lo;

  always_comb begin
    ex           = '0;
    ex.kind      = K_DONE;
    ex.npc       = pc;
    ex.a         = a;
    ex.x         = x;
    ex.p         = p;
    ex.sp        = sp;
    ex.cyc       = 3'd2;
    br_en        = 1'b0;
    br_take      = 1'b0;

    unique case (cmd)
      OP_BRK: begin
        ex.kind      = K_PUSH;
        ex.st_we     = 1'b1;
        ex.st_data   = pc2[15:8];
        ex.sp        = sp - 8'd1;
        ex.push_left = 2'd2;
        ex.push_b0   = pc2[7:0];
        ex.push_b1   = p | FLAG_B;
      end
      OP_JSR: begin
        ex.kind      = K_PUSH;
        ex.st_we     = 1'b1;
        ex.st_data   = pc2[15:8];
        ex.sp        = sp - 8'd1;
        ex.push_left = 2'd1;
        ex.push_b0   = pc2[7:0];
      end
      OP_PHP: begin
        ex.st_we   = 1'b1;
        ex.st_data = p | FLAG_B;
        ex.sp      = sp - 8'd1;
        ex.npc     = pc1;
        ex.cyc     = 3'd3;
      end
      OP_PHA: begin
        ex.st_we   = 1'b1;
        ex.st_data = a;
        ex.sp      = sp - 8'd1;
        ex.npc     = pc1;
        ex.cyc     = 3'd3;
      end
      OP_PLP, OP_PLA: begin
        ex.kind      = K_PULL;
        ex.st_rd     = 1'b1;
        ex.sp        = sp + 8'd1;
        ex.pull_last = 2'd0;
      end
      OP_RTS: begin
        ex.kind      = K_PULL;
        ex.st_rd     = 1'b1;
        ex.sp        = sp + 8'd1;
        ex.pull_last = 2'd1;
      end
      OP_RTI: begin
        ex.kind      = K_PULL;
        ex.st_rd     = 1'b1;
        ex.sp        = sp + 8'd1;
        ex.pull_last = 2'd2;
      end
      OP_ORA_IMM: begin
        ex.a   = a | lo;
        ex.p   = set_nz(p, a | lo);
        ex.npc = pc2;
      end
      OP_AND_IMM: begin
        ex.a   = a & lo;
        ex.p   = set_nz(p, a & lo);
        ex.npc = pc2;
      end
      OP_EOR_IMM: begin
        ex.a   = a ^ lo;
        ex.p   = set_nz(p, a ^ lo);
        ex.npc = pc2;
      end
      OP_CMP_IMM: begin
        ex.p   = set_nz((a >= lo) ? (p | FLAG_C) : (p & ~FLAG_C), cmp_diff);
        ex.npc = pc2;
      end
      OP_BIT_ZP: begin
        ex.p = p & ~(FLAG_N | FLAG_V | FLAG_Z);
        if ((a & mem_data) == 8'h00) ex.p = ex.p | FLAG_Z;
        if (mem_data[7]) ex.p = ex.p | FLAG_N;
        if (mem_data[6]) ex.p = ex.p | FLAG_V;
        ex.npc = pc2;
        ex.cyc = 3'd3;
      end
      OP_LDX_IMM: begin
        ex.x   = lo;
        ex.p   = set_nz(p, lo);
        ex.npc = pc2;
      end
      OP_LDA_IMM: begin
        ex.a   = lo;
        ex.p   = set_nz(p, lo);
        ex.npc = pc2;
      end
      OP_LDA_ABS: begin
        ex.a   = mem_data;
        ex.p   = set_nz(p, mem_data);
        ex.npc = pc3;
        ex.cyc = 3'd4;
      end
      OP_STA_ZP: begin
        ex.wr    = 1'b1;
        ex.waddr = {8'h00, lo};
        ex.wdata = a;
        ex.npc   = pc2;
        ex.cyc   = 3'd3;
      end
      OP_STX_ZP: begin
        ex.wr    = 1'b1;
        ex.waddr = {8'h00, lo};
        ex.wdata = x;
        ex.npc   = pc2;
        ex.cyc   = 3'd3;
      end
      OP_STA_ABS: begin
        ex.wr    = 1'b1;
        ex.waddr = operand;
        ex.wdata = a;
        ex.npc   = pc3;
        ex.cyc   = 3'd4;
      end
      OP_JMP_ABS: begin
        ex.npc = operand;
        ex.cyc = 3'd3;
      end
      OP_TXS: begin
        ex.sp  = x;
        ex.npc = pc1;
      end
      OP_CLC: begin ex.p = p & ~FLAG_C; ex.npc = pc1; end
      OP_SEC: begin ex.p = p | FLAG_C;  ex.npc = pc1; end
      OP_SEI: begin ex.p = p | FLAG_I;  ex.npc = pc1; end
      OP_CLV: begin ex.p = p & ~FLAG_V; ex.npc = pc1; end
      OP_CLD: begin ex.p = p & ~FLAG_D; ex.npc = pc1; end
      OP_SED: begin ex.p = p | FLAG_D;  ex.npc = pc1; end
      OP_NOP: begin ex.npc = pc1; end
      OP_BPL: begin br_en = 1'b1; br_take = (p & FLAG_N) == 8'h00; end
      OP_BMI: begin br_en = 1'b1; br_take = (p & FLAG_N) != 8'h00; end
      OP_BVC: begin br_en = 1'b1; br_take = (p & FLAG_V) == 8'h00; end
      OP_BVS: begin br_en = 1'b1; br_take = (p & FLAG_V) != 8'h00; end
      OP_BCC: begin br_en = 1'b1; br_take = (p & FLAG_C) == 8'h00; end
      OP_BCS: begin br_en = 1'b1; br_take = (p & FLAG_C) != 8'h00; end
      OP_BNE: begin br_en = 1'b1; br_take = (p & FLAG_Z) == 8'h00; end
      OP_BEQ: begin br_en = 1'b1; br_take = (p & FLAG_Z) != 8'h00; end
      default: begin
        ex.illegal = 1'b1;
      end
    endcase

    // Page crossing counts against the address of the next instruction
    if (br_en) begin
      if (br_take) begin
        ex.npc = btgt;
        ex.cyc = (pc2[15:8] != btgt[15:8]) ? 3'd4 : 3'd3;
      end else begin
        ex.npc = pc2;
        ex.cyc = 3'd2;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cpu6502_subset_execute.sv
// Top level: 6502 subset execute unit with the stack page held in a RAM.
// Results: a result is registered in the output register as its instruction completes;
//   JSR, BRK, PLA, PLP, RTS and RTI first step through S_PUSH or S_PULL for the stack.
// Throughput: one instruction per cycle while the output is not stalled; stack sequences
//   hold the input while they use the single stack RAM port (one access per cycle).
// Reset: synchronous; registers take their reset values and the stack page reads as zero
//   through per-entry valid bits, so no clearing pass runs.
`default_nettype none

module cpu6502_subset_execute
  import c6se_pkg::*;
#(
  parameter int STACK_BYTES = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: cmd[7:0], operand[23:8], mem_data[31:24]
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_W-1:0]       in_tdata,
  // out_tdata: next_pc[15:0], acc[23:16], index_x[31:24], flags[39:32],
  //   stack_ptr[47:40], wr_valid[48], wr_addr[64:49], wr_data[72:65],
  //   cycles_taken[75:73], illegal[76], zero fill[79:77]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_W-1:0]           out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SAW = $clog2(STACK_BYTES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PUSH = 3'b010,
    S_PULL = 3'b100
  } state_t;

  // Control and architectural state
  state_t               state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [15:0]          pc_r, pc_nxt;
  logic [7:0]           a_r, a_nxt;
  logic [7:0]           x_r, x_nxt;
  logic [7:0]           p_r, p_nxt;
  logic [7:0]           sp_r, sp_nxt;
  logic [15:0]          brk_vec_r, brk_vec_nxt;
  logic [15:0]          start_r, start_nxt;
  logic [1:0]           push_left_r, push_left_nxt;
  logic [1:0]           pull_idx_r, pull_idx_nxt;
  logic [1:0]           pull_last_r, pull_last_nxt;
  logic [STACK_BYTES-1:0] vld_r;
  logic                 rd_vld_r;

  // Payload held across a stack sequence
  logic [7:0]           op_r, op_nxt;
  logic [15:0]          opnd_r, opnd_nxt;
  logic [7:0]           b0_r, b0_nxt;
  logic [7:0]           b1_r, b1_nxt;
  logic [7:0]           h0_r, h0_nxt;
  logic [7:0]           h1_r, h1_nxt;
  c6se_result_t         out_res_r, out_res_nxt;

  // Stack RAM port
  logic                 st_we, st_re;
  logic [SAW-1:0]       st_waddr, st_raddr;
  logic [7:0]           st_wdata, st_rdata, rd_byte;
  logic [7:0]           sp_inc;

  logic                 out_ok, in_fire;
  c6se_exec_t           ex;

  assign out_ok    = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_ok;
  assign in_fire   = in_tvalid && in_tready;
  assign sp_inc    = sp_r + 8'd1;

  // A never-written entry of the stack page reads as zero
  assign rd_byte = rd_vld_r ? st_rdata : 8'h00;

  c6se_decode u_decode (
    .cmd      (in_tdata[7:0]),
    .operand  (in_tdata[23:8]),
    .mem_data (in_tdata[31:24]),
    .pc       (pc_r),
    .a        (a_r),
    .x        (x_r),
    .p        (p_r),
    .sp       (sp_r),
    .ex       (ex)
  );

  c6se_ram #(
    .WIDTH (8),
    .DEPTH (STACK_BYTES)
  ) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    pc_nxt        = pc_r;
    a_nxt         = a_r;
    x_nxt         = x_r;
    p_nxt         = p_r;
    sp_nxt        = sp_r;
    brk_vec_nxt   = brk_vec_r;
    start_nxt     = start_r;
    push_left_nxt = push_left_r;
    pull_idx_nxt  = pull_idx_r;
    pull_last_nxt = pull_last_r;
    op_nxt        = op_r;
    opnd_nxt      = opnd_r;
    b0_nxt        = b0_r;
    b1_nxt        = b1_r;
    h0_nxt        = h0_r;
    h1_nxt        = h1_r;
    st_we         = 1'b0;
    st_waddr      = sp_r[SAW-1:0];
    st_wdata      = b0_r;
    st_re         = 1'b0;
    st_raddr      = sp_inc[SAW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_tdata[7:0];
          opnd_nxt = in_tdata[23:8];
          pc_nxt   = ex.npc;
          a_nxt    = ex.a;
          x_nxt    = ex.x;
          p_nxt    = ex.p;
          sp_nxt   = ex.sp;
          st_we    = ex.st_we;
          st_wdata = ex.st_data;
          st_re    = ex.st_rd;
          if (ex.kind == K_DONE) begin
            // Whole instruction finishes now: load the result
            out_valid_nxt       = 1'b1;
            out_res_nxt.npc     = ex.npc;
            out_res_nxt.a       = ex.a;
            out_res_nxt.x       = ex.x;
            out_res_nxt.p       = ex.p;
            out_res_nxt.sp      = ex.sp;
            out_res_nxt.wr      = ex.wr;
            out_res_nxt.waddr   = ex.waddr;
            out_res_nxt.wdata   = ex.wdata;
            out_res_nxt.cyc     = ex.cyc;
            out_res_nxt.illegal = ex.illegal;
          end else if (ex.kind == K_PUSH) begin
            state_nxt     = S_PUSH;
            push_left_nxt = ex.push_left;
            b0_nxt        = ex.push_b0;
            b1_nxt        = ex.push_b1;
          end else begin
            state_nxt     = S_PULL;
            pull_idx_nxt  = 2'd0;
            pull_last_nxt = ex.pull_last;
          end
        end
      end

      S_PUSH: begin
        if (push_left_r != 2'd1) begin
          // Intermediate push: write, decrement SP, advance the byte queue
          st_we         = 1'b1;
          sp_nxt        = sp_r - 8'd1;
          b0_nxt        = b1_r;
          push_left_nxt = push_left_r - 2'd1;
        end else if (out_ok) begin
          // Last push completes the instruction
          st_we               = 1'b1;
          sp_nxt              = sp_r - 8'd1;
          state_nxt           = S_IDLE;
          out_valid_nxt       = 1'b1;
          out_res_nxt         = '0;
          out_res_nxt.a       = a_r;
          out_res_nxt.x       = x_r;
          out_res_nxt.sp      = sp_r - 8'd1;
          if (op_r == OP_BRK) begin
            p_nxt           = p_r | FLAG_I;
            pc_nxt          = brk_vec_r;
            out_res_nxt.cyc = 3'd7;
          end else begin
            p_nxt           = p_r;
            pc_nxt          = opnd_r;
            out_res_nxt.cyc = 3'd6;
          end
          out_res_nxt.p   = p_nxt;
          out_res_nxt.npc = pc_nxt;
        end
      end

      S_PULL: begin
        if (pull_idx_r != pull_last_r) begin
          // Capture this byte and issue the next read
          if (pull_idx_r == 2'd0) begin
            h0_nxt = rd_byte;
          end else begin
            h1_nxt = rd_byte;
          end
          st_re        = 1'b1;
          sp_nxt       = sp_inc;
          pull_idx_nxt = pull_idx_r + 2'd1;
        end else if (out_ok) begin
          // Final byte is on the RAM output; it holds while the result side stalls
          state_nxt = S_IDLE;
          unique case (op_r)
            OP_PLA: begin
              a_nxt  = rd_byte;
              p_nxt  = set_nz(p_r, rd_byte);
              pc_nxt = pc_r + 16'd1;
            end
            OP_PLP: begin
              p_nxt  = rd_byte & ~FLAG_B;
              pc_nxt = pc_r + 16'd1;
            end
            OP_RTS: begin
              pc_nxt = {rd_byte, h0_r} + 16'd1;
            end
            default: begin
              p_nxt  = h0_r & ~FLAG_B;
              pc_nxt = {rd_byte, h1_r};
            end
          endcase
          out_valid_nxt     = 1'b1;
          out_res_nxt       = '0;
          out_res_nxt.npc   = pc_nxt;
          out_res_nxt.a     = a_nxt;
          out_res_nxt.x     = x_r;
          out_res_nxt.p     = p_nxt;
          out_res_nxt.sp    = sp_r;
          out_res_nxt.cyc   = ((op_r == OP_PLA) || (op_r == OP_PLP)) ? 3'd4 : 3'd6;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // The user writes configuration only while idle (unchecked); start address loads PC
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BRK_VECTOR: brk_vec_nxt = cfg_wdata;
        CFG_START_ADDR: begin
          start_nxt = cfg_wdata;
          pc_nxt    = cfg_wdata;
        end
        default: begin
          start_nxt = start_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= RESET_START;
      a_r         <= 8'h00;
      x_r         <= 8'h00;
      p_r         <= 8'h00;
      sp_r        <= 8'h00;
      brk_vec_r   <= 16'h0000;
      start_r     <= RESET_START;
      push_left_r <= 2'd0;
      pull_idx_r  <= 2'd0;
      pull_last_r <= 2'd0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pc_r        <= pc_nxt;
      a_r         <= a_nxt;
      x_r         <= x_nxt;
      p_r         <= p_nxt;
      sp_r        <= sp_nxt;
      brk_vec_r   <= brk_vec_nxt;
      start_r     <= start_nxt;
      push_left_r <= push_left_nxt;
      pull_idx_r  <= pull_idx_nxt;
      pull_last_r <= pull_last_nxt;
      if (st_we) begin
        vld_r[st_waddr] <= 1'b1;
      end
      if (st_re) begin
        rd_vld_r <= vld_r[st_raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    opnd_r    <= opnd_nxt;
    b0_r      <= b0_nxt;
    b1_r      <= b1_nxt;
    h0_r      <= h0_nxt;
    h1_r      <= h1_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r.illegal, out_res_r.cyc, out_res_r.wdata,
                       out_res_r.waddr, out_res_r.wr, out_res_r.sp, out_res_r.p,
                       out_res_r.x, out_res_r.a, out_res_r.npc};

endmodule

`default_nettype wire

FILE: rtl/c6se_checker.sv
// Port-level checker for the execute block and its bind to the top level.
`default_nettype none

module c6se_checker
  import c6se_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_W-1:0]      out_tdata,
  input wire logic                  cfg_we,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic        out_fire;
  logic [15:0] last_pc_r;
  logic [7:0]  last_a_r, last_x_r, last_sp_r;

  assign out_fire = out_tvalid && out_tready;

  // Track the register view left by the last delivered transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pc_r <= RESET_START;
      last_a_r  <= 8'h00;
      last_x_r  <= 8'h00;
      last_sp_r <= 8'h00;
    end else if (out_fire) begin
      last_pc_r <= out_tdata[15:0];
      last_a_r  <= out_tdata[23:16];
      last_x_r  <= out_tdata[31:24];
      last_sp_r <= out_tdata[47:40];
    end else if (cfg_we && (cfg_index == CFG_START_ADDR)) begin
      last_pc_r <= cfg_wdata;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result transaction dropped while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_illegal_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_tdata[76] |->
      (out_tdata[15:0] == last_pc_r) && (out_tdata[23:16] == last_a_r) &&
      (out_tdata[31:24] == last_x_r) && (out_tdata[47:40] == last_sp_r) &&
      !out_tdata[48] && (out_tdata[75:73] == 3'd2))
    else $error("illegal opcode changed state");

  a_store_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_tdata[48] |->
      ((out_tdata[75:73] == 3'd3) || (out_tdata[75:73] == 3'd4)) &&
      (out_tdata[15:0] != last_pc_r))
    else $error("store with wrong cycle count or stuck PC");

endmodule

bind cpu6502_subset_execute c6se_checker u_c6se_checker (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the 6502 subset execute unit.
module testbench;
  import c6se_pkg::*;

  // Cycles without any transaction on either stream before the run is declared hung
  localparam int unsigned HANG_LIMIT = 2000;
  // Instructions per random phase; five phases plus the directed part
  localparam int unsigned PHASE_INSNS = 130;

  // Architectural mirror of the execute unit: PC, A, X, P, SP, the stack page
  // and both configuration registers. Each accepted instruction is executed
  // here and the resulting register view is queued until the unit reports it.
  class cpu_mirror;
    logic [15:0] brk_vec;
    logic [15:0] start_pc;
    logic [15:0] pc;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  p;
    logic [7:0]  sp;
    logic [7:0]  stack_mem [256];
    c6se_result_t predicted_states[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      brk_vec = 16'h0000;
      start_pc = RESET_START;
      pc = RESET_START;
      a = 8'h00;
      x = 8'h00;
      p = 8'h00;
      sp = 8'h00;
      foreach (stack_mem[i]) stack_mem[i] = 8'h00;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function int unsigned pending_count();
      return predicted_states.size();
    endfunction

    // A start address write also reloads the program counter
    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
      if (idx == CFG_BRK_VECTOR) begin
        brk_vec = val;
      end else if (idx == CFG_START_ADDR) begin
        start_pc = val;
        pc = val;
      end
    endfunction

    // Push stores at SP then decrements; pull increments then reads
    function void push_stack(input logic [7:0] v);
      stack_mem[sp] = v;
      sp = sp - 8'd1;
    endfunction

    function logic [7:0] pull_stack();
      sp = sp + 8'd1;
      return stack_mem[sp];
    endfunction

    function void put_flag(input logic [7:0] mask, input logic on);
      p = on ? (p | mask) : (p & ~mask);
    endfunction

    function void load_nz(input logic [7:0] v);
      put_flag(FLAG_N, v[7]);
      put_flag(FLAG_Z, v == 8'h00);
    endfunction

    function void note_instruction(input logic [7:0] cmd, input logic [15:0] opnd,
                                   input logic [7:0] mem);
      c6se_result_t r;
      logic [7:0]   lo;
      logic [7:0]   diff;
      logic [7:0]   pl;
      logic [7:0]   ph;
      logic [15:0]  ret;
      logic [15:0]  fall;
      logic [15:0]  tgt;
      logic         is_branch;
      logic         taken;
      lo = opnd[7:0];
      r = '0;
      r.npc = pc;
      r.cyc = 3'd2;
      is_branch = 1'b0;
      taken = 1'b0;
      case (cmd)
        OP_BRK: begin
          ret = pc + 16'd2;
          push_stack(ret[15:8]);
          push_stack(ret[7:0]);
          push_stack(p | FLAG_B);
          p = p | FLAG_I;
          r.npc = brk_vec;
          r.cyc = 3'd7;
        end
        OP_PHP: begin
          push_stack(p | FLAG_B);
          r.npc = pc + 16'd1;
          r.cyc = 3'd3;
        end
        OP_ORA_IMM: begin
          a = a | lo;
          load_nz(a);
          r.npc = pc + 16'd2;
        end
        OP_CLC: begin
          put_flag(FLAG_C, 1'b0);
          r.npc = pc + 16'd1;
        end
        OP_JSR: begin
          ret = pc + 16'd2;
          push_stack(ret[15:8]);
          push_stack(ret[7:0]);
          r.npc = opnd;
          r.cyc = 3'd6;
        end
        OP_BIT_ZP: begin
          put_flag(FLAG_Z, (a & mem) == 8'h00);
          put_flag(FLAG_N, mem[7]);
          put_flag(FLAG_V, mem[6]);
          r.npc = pc + 16'd2;
          r.cyc = 3'd3;
        end
        OP_PLP: begin
          p = pull_stack() & ~FLAG_B;
          r.npc = pc + 16'd1;
          r.cyc = 3'd4;
        end
        OP_AND_IMM: begin
          a = a & lo;
          load_nz(a);
          r.npc = pc + 16'd2;
        end
        OP_SEC: begin
          put_flag(FLAG_C, 1'b1);
          r.npc = pc + 16'd1;
        end
        OP_RTI: begin
          p = pull_stack() & ~FLAG_B;
          pl = pull_stack();
          ph = pull_stack();
          r.npc = {ph, pl};
          r.cyc = 3'd6;
        end
        OP_PHA: begin
          push_stack(a);
          r.npc = pc + 16'd1;
          r.cyc = 3'd3;
        end
        OP_EOR_IMM: begin
          a = a ^ lo;
          load_nz(a);
          r.npc = pc + 16'd2;
        end
        OP_JMP_ABS: begin
          r.npc = opnd;
          r.cyc = 3'd3;
        end
        OP_RTS: begin
          pl = pull_stack();
          ph = pull_stack();
          r.npc = {ph, pl} + 16'd1;
          r.cyc = 3'd6;
        end
        OP_PLA: begin
          a = pull_stack();
          load_nz(a);
          r.npc = pc + 16'd1;
          r.cyc = 3'd4;
        end
        OP_SEI: begin
          put_flag(FLAG_I, 1'b1);
          r.npc = pc + 16'd1;
        end
        OP_STA_ZP: begin
          r.wr = 1'b1;
          r.waddr = {8'h00, lo};
          r.wdata = a;
          r.npc = pc + 16'd2;
          r.cyc = 3'd3;
        end
        OP_STX_ZP: begin
          r.wr = 1'b1;
          r.waddr = {8'h00, lo};
          r.wdata = x;
          r.npc = pc + 16'd2;
          r.cyc = 3'd3;
        end
        OP_STA_ABS: begin
          r.wr = 1'b1;
          r.waddr = opnd;
          r.wdata = a;
          r.npc = pc + 16'd3;
          r.cyc = 3'd4;
        end
        OP_TXS: begin
          sp = x;
          r.npc = pc + 16'd1;
        end
        OP_LDX_IMM: begin
          x = lo;
          load_nz(x);
          r.npc = pc + 16'd2;
        end
        OP_LDA_IMM: begin
          a = lo;
          load_nz(a);
          r.npc = pc + 16'd2;
        end
        OP_LDA_ABS: begin
          a = mem;
          load_nz(a);
          r.npc = pc + 16'd3;
          r.cyc = 3'd4;
        end
        OP_CLV: begin
          put_flag(FLAG_V, 1'b0);
          r.npc = pc + 16'd1;
        end
        OP_CMP_IMM: begin
          put_flag(FLAG_C, a >= lo);
          diff = a - lo;
          load_nz(diff);
          r.npc = pc + 16'd2;
        end
        OP_CLD: begin
          put_flag(FLAG_D, 1'b0);
          r.npc = pc + 16'd1;
        end
        OP_NOP: r.npc = pc + 16'd1;
        OP_SED: begin
          put_flag(FLAG_D, 1'b1);
          r.npc = pc + 16'd1;
        end
        OP_BPL: begin is_branch = 1'b1; taken = (p & FLAG_N) == 8'h00; end
        OP_BMI: begin is_branch = 1'b1; taken = (p & FLAG_N) != 8'h00; end
        OP_BVC: begin is_branch = 1'b1; taken = (p & FLAG_V) == 8'h00; end
        OP_BVS: begin is_branch = 1'b1; taken = (p & FLAG_V) != 8'h00; end
        OP_BCC: begin is_branch = 1'b1; taken = (p & FLAG_C) == 8'h00; end
        OP_BCS: begin is_branch = 1'b1; taken = (p & FLAG_C) != 8'h00; end
        OP_BNE: begin is_branch = 1'b1; taken = (p & FLAG_Z) == 8'h00; end
        OP_BEQ: begin is_branch = 1'b1; taken = (p & FLAG_Z) != 8'h00; end
        default: r.illegal = 1'b1;
      endcase
      if (is_branch) begin
        fall = pc + 16'd2;
        if (taken) begin
          tgt = fall + {{8{lo[7]}}, lo};
          r.cyc = (fall[15:8] != tgt[15:8]) ? 3'd4 : 3'd3;
          r.npc = tgt;
        end else begin
          r.npc = fall;
          r.cyc = 3'd2;
        end
      end
      pc = r.npc;
      r.a = a;
      r.x = x;
      r.p = p;
      r.sp = sp;
      predicted_states.push_back(r);
    endfunction

    function string show(input c6se_result_t r);
      return $sformatf("pc=%h a=%h x=%h p=%h sp=%h wr=%b addr=%h data=%h cyc=%0d ill=%b",
                       r.npc, r.a, r.x, r.p, r.sp, r.wr, r.waddr, r.wdata, r.cyc, r.illegal);
    endfunction

    function void check_result(input logic [OUT_W-1:0] d);
      c6se_result_t got;
      c6se_result_t want;
      got.npc     = d[15:0];
      got.a       = d[23:16];
      got.x       = d[31:24];
      got.p       = d[39:32];
      got.sp      = d[47:40];
      got.wr      = d[48];
      got.waddr   = d[64:49];
      got.wdata   = d[72:65];
      got.cyc     = d[75:73];
      got.illegal = d[76];
      results_seen++;
      if (predicted_states.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing outstanding: %s", results_seen, show(got));
        return;
      end
      want = predicted_states.pop_front();
      if (got.npc !== want.npc || got.a !== want.a || got.x !== want.x ||
          got.p !== want.p || got.sp !== want.sp || got.wr !== want.wr ||
          got.waddr !== want.waddr || got.wdata !== want.wdata ||
          got.cyc !== want.cyc || got.illegal !== want.illegal) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch", results_seen);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  cpu_mirror   sb;
  bit          idling_on = 1'b1;
  int unsigned insn_sent = 0;
  int unsigned quiet_cycles = 0;

  // Every opcode of the subset, and the ones that leave the stack alone
  // (used as the body of call and push/pull sequences)
  logic [7:0] subset_ops [0:35] = '{
    OP_BRK, OP_PHP, OP_ORA_IMM, OP_BPL, OP_CLC, OP_JSR, OP_BIT_ZP, OP_PLP, OP_AND_IMM,
    OP_BMI, OP_SEC, OP_RTI, OP_PHA, OP_EOR_IMM, OP_JMP_ABS, OP_BVC, OP_RTS, OP_PLA,
    OP_BVS, OP_SEI, OP_STA_ZP, OP_STX_ZP, OP_STA_ABS, OP_BCC, OP_TXS, OP_LDX_IMM,
    OP_LDA_IMM, OP_LDA_ABS, OP_BCS, OP_CLV, OP_CMP_IMM, OP_BNE, OP_CLD, OP_NOP, OP_BEQ,
    OP_SED
  };
  logic [7:0] body_ops [0:26] = '{
    OP_ORA_IMM, OP_AND_IMM, OP_EOR_IMM, OP_CMP_IMM, OP_LDA_IMM, OP_LDX_IMM, OP_LDA_ABS,
    OP_BIT_ZP, OP_STA_ZP, OP_STX_ZP, OP_STA_ABS, OP_CLC, OP_SEC, OP_SEI, OP_CLV, OP_CLD,
    OP_SED, OP_NOP, OP_JMP_ABS, OP_BPL, OP_BMI, OP_BVC, OP_BVS, OP_BCC, OP_BCS, OP_BNE,
    OP_BEQ
  };

  cpu6502_subset_execute dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Operand and data generators lean on the extremes now and then
  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      3: return 16'($urandom_range(16'hFF00, 16'hFFFF));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Present one instruction and hold it until the unit takes it. Called at a
  // falling edge; returns at the falling edge after the transaction.
  task automatic issue(input logic [7:0] cmd, input logic [15:0] opnd, input logic [7:0] mem);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tdata = {mem, opnd, cmd};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_instruction(cmd, opnd, mem);
    insn_sent++;
    @(negedge clk);
  endtask

  task automatic issue_body();
    issue(body_ops[$urandom_range(0, 26)], rand_word(), rand_byte());
  endtask

  // Drop valid and wait until every outstanding result has come back; every
  // instruction yields exactly one result, so the unit is idle afterwards
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_index = idx;
    cfg_wdata = val;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Short directed pass: every opcode, flag extremes, page-crossing branches
  // in both directions, PC wrap, stack wrap and illegal opcodes
  task automatic run_directed();
    issue(OP_LDA_IMM, 16'hFF00, 8'hFF);     // zero result, upper operand bits ignored
    issue(OP_LDA_IMM, 16'h0080, 8'h00);     // negative result
    issue(OP_LDX_IMM, 16'h00FF, 8'h00);
    issue(OP_TXS, 16'h0000, 8'h00);
    issue(OP_PHA, 16'hFFFF, 8'hFF);
    issue(OP_PHP, 16'h0000, 8'h00);         // B set in the pushed copy
    issue(OP_PLA, 16'h0000, 8'h00);
    issue(OP_PLP, 16'h0000, 8'h00);         // B dropped on the way back
    issue(OP_PLA, 16'h0000, 8'h00);         // wraps SP past FF
    issue(OP_ORA_IMM, 16'h000F, 8'h00);
    issue(OP_AND_IMM, 16'h00F0, 8'h00);
    issue(OP_EOR_IMM, 16'h00FF, 8'h00);
    issue(OP_CMP_IMM, 16'h00FF, 8'h00);
    issue(OP_CMP_IMM, 16'h0000, 8'h00);
    issue(OP_BIT_ZP, 16'h0010, 8'hC0);
    issue(OP_BIT_ZP, 16'h00FF, 8'h3F);
    issue(OP_SEC, 16'h0000, 8'h00);
    issue(OP_SED, 16'h0000, 8'h00);
    issue(OP_SEI, 16'h0000, 8'h00);
    issue(OP_CLV, 16'h0000, 8'h00);
    issue(OP_CLD, 16'h0000, 8'h00);
    issue(OP_CLC, 16'h0000, 8'h00);
    issue(OP_NOP, 16'h0000, 8'h00);
    issue(OP_JMP_ABS, 16'h10F0, 8'h00);
    issue(OP_BCC, 16'h007F, 8'h00);         // taken, forward into the next page
    issue(OP_BCS, 16'h0000, 8'h00);         // not taken
    issue(OP_SEC, 16'h0000, 8'h00);
    issue(OP_BCS, 16'h0080, 8'h00);         // taken, backward into the previous page
    issue(OP_BCS, 16'h0002, 8'h00);         // taken, same page
    issue(OP_BPL, rand_word(), rand_byte());
    issue(OP_BMI, rand_word(), rand_byte());
    issue(OP_BVC, rand_word(), rand_byte());
    issue(OP_BVS, rand_word(), rand_byte());
    issue(OP_BNE, rand_word(), rand_byte());
    issue(OP_BEQ, rand_word(), rand_byte());
    issue(OP_JSR, 16'hFFFF, 8'h00);
    issue(OP_RTS, 16'h0000, 8'h00);
    issue(OP_BRK, 16'h0000, 8'h00);
    issue(OP_RTI, 16'h0000, 8'h00);
    issue(OP_STA_ZP, 16'hFF85, 8'h00);      // zero-page store keeps only the low byte
    issue(OP_STX_ZP, 16'h0000, 8'h00);
    issue(OP_STA_ABS, 16'hFFFF, 8'h00);
    issue(OP_LDA_ABS, 16'h1234, 8'hFF);
    issue(OP_LDA_ABS, 16'h0000, 8'h00);
    issue(OP_JMP_ABS, 16'hFFFE, 8'h00);
    issue(OP_NOP, 16'h0000, 8'h00);
    issue(OP_NOP, 16'h0000, 8'h00);         // PC wraps to 0000
    issue(8'h02, 16'hFFFF, 8'hFF);          // illegal opcodes leave state alone
    issue(8'hFF, 16'h0000, 8'h00);
  endtask

  // Random mix: single subset opcodes, balanced call/return and push/pull
  // sequences with random bodies, and raw opcode bytes over the full range
  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    int unsigned sel;
    bit          via_brk;
    bit          status_pair;
    stop_at = insn_sent + count;
    while (insn_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        issue(subset_ops[$urandom_range(0, 35)], rand_word(), rand_byte());
      end else if (sel < 70) begin
        via_brk = $urandom_range(0, 1);
        issue(via_brk ? OP_BRK : OP_JSR, rand_word(), rand_byte());
        repeat ($urandom_range(0, 3)) issue_body();
        issue(via_brk ? OP_RTI : OP_RTS, rand_word(), rand_byte());
      end else if (sel < 82) begin
        status_pair = $urandom_range(0, 1);
        issue(status_pair ? OP_PHP : OP_PHA, rand_word(), rand_byte());
        repeat ($urandom_range(0, 2)) issue_body();
        issue(status_pair ? OP_PLP : OP_PLA, rand_word(), rand_byte());
      end else begin
        issue(8'($urandom_range(0, 255)), rand_word(), rand_byte());
      end
    end
  endtask

  // Result side: random stall bursts while idling is on
  initial begin : ready_driver
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_tready = 1'b0;
        hold = $urandom_range(1, 8) - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Check every result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Hang detection: count cycles with no transaction on either stream
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Reset values first: default break vector and start address
    run_directed();

    // Extreme settings, then mid-range ones; drain before each change
    drain();
    write_cfg(CFG_BRK_VECTOR, 16'hFFFF);
    write_cfg(CFG_START_ADDR, 16'h0000);
    run_random(PHASE_INSNS);

    drain();
    write_cfg(CFG_BRK_VECTOR, 16'h0000);
    write_cfg(CFG_START_ADDR, 16'hFFFF);
    run_random(PHASE_INSNS);

    drain();
    write_cfg(CFG_BRK_VECTOR, 16'h00FF);
    write_cfg(CFG_START_ADDR, 16'hFFF0);
    run_random(PHASE_INSNS);

    drain();
    write_cfg(CFG_BRK_VECTOR, 16'($urandom_range(0, 65535)));
    write_cfg(CFG_START_ADDR, 16'($urandom_range(0, 65535)));
    run_random(PHASE_INSNS);

    // Last phase runs back to back on both sides
    drain();
    idling_on = 1'b0;
    write_cfg(CFG_BRK_VECTOR, 16'h8000);
    write_cfg(CFG_START_ADDR, 16'h00FE);
    run_random(PHASE_INSNS);

    // Let the last results land, then wait for stray ones
    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/c6se_pkg.sv
rtl/c6se_ram.sv
rtl/c6se_decode.sv
rtl/cpu6502_subset_execute.sv
rtl/c6se_checker.sv
tb/sv/testbench.sv
